// File: src/rxs_pkg.sv
// Shared opcodes, status codes, register map and reset values of the execute stage.
package rxs_pkg;

  // Opcodes, register form.
  localparam logic [5:0] OP_ADD  = 6'h00;
  localparam logic [5:0] OP_SUB  = 6'h02;
  localparam logic [5:0] OP_MUL  = 6'h04;
  localparam logic [5:0] OP_OR   = 6'h06;
  localparam logic [5:0] OP_AND  = 6'h08;
  localparam logic [5:0] OP_XOR  = 6'h0A;

  // Opcodes, immediate form.
  localparam logic [5:0] OP_ADDI = 6'h01;
  localparam logic [5:0] OP_SUBI = 6'h03;
  localparam logic [5:0] OP_MULI = 6'h05;
  localparam logic [5:0] OP_ORI  = 6'h07;
  localparam logic [5:0] OP_ANDI = 6'h09;
  localparam logic [5:0] OP_XORI = 6'h0B;
  localparam logic [5:0] OP_LDW  = 6'h0C;
  localparam logic [5:0] OP_STW  = 6'h0D;
  localparam logic [5:0] OP_BZ   = 6'h0E;
  localparam logic [5:0] OP_BEQ  = 6'h0F;
  localparam logic [5:0] OP_JR   = 6'h10;
  localparam logic [5:0] OP_HALT = 6'h11;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_OP  = 2'd1;
  localparam logic [1:0] STAT_BAD_ADR = 2'd2;
  localparam logic [1:0] STAT_HALT    = 2'd3;

  // Pipeline modes.
  localparam logic [1:0] MODE_FUNC      = 2'd0;
  localparam logic [1:0] MODE_PIPE_NOFW = 2'd1;
  localparam logic [1:0] MODE_PIPE_FW   = 2'd2;

  // Register map: register i at byte address 4*i.
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_MODE    = 1'b0;
  localparam logic        REG_MEMSIZE = 1'b1;

  localparam int unsigned MEMW_W = 21;
  localparam logic [MEMW_W-1:0] MEMW_RESET = 21'd1024;

  // PC adjustments in bytes.
  localparam logic [31:0] PC_STEP      = 32'd4;
  localparam logic [31:0] PC_PIPE_BACK = 32'd8;

endpackage

// File: src/rxs_if.sv
// Stream interfaces that carry decoded instructions in and execute results out.
interface rxs_in_if;
  logic               valid;
  logic               ready;
  logic               is_r_type;
  logic        [5:0]  op;
  logic signed [31:0] rs_value;
  logic signed [31:0] rt_value;
  logic signed [15:0] immediate;
  logic        [31:0] pc_in;

  modport source (output valid, is_r_type, op, rs_value, rt_value, immediate, pc_in,
                  input ready);
  modport sink   (input valid, is_r_type, op, rs_value, rt_value, immediate, pc_in,
                  output ready);
endinterface

interface rxs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] alu_value;
  logic        [31:0] next_pc;
  logic               pc_written;
  logic               branch_flag;
  logic        [1:0]  status;
  logic        [31:0] instruction_total;
  logic        [31:0] halt_total;

  modport source (output valid, alu_value, next_pc, pc_written, branch_flag, status,
                  instruction_total, halt_total, input ready);
  modport sink   (input valid, alu_value, next_pc, pc_written, branch_flag, status,
                  instruction_total, halt_total, output ready);
endinterface

// File: src/risc_execute_stage_top.sv
// Execute stage of a small load/store processor: ALU, address check, branch and counters.

// The stage takes one decoded instruction per clock cycle while its results are taken and
// returns exactly one result for each, in order. An instruction is first captured in an
// input register; the ALU, the address range check and the branch/jump target logic then
// work on it in one pass and the result lands in the output register, from which it is
// offered. The sustained rate is one instruction per cycle while results are taken. The
// longest path is the DATA_WIDTH-bit multiplier of MUL/MULI. Both registers advance
// together when the output is free or being taken; while a finished result waits for its
// transfer, the input register can still take one more instruction, after which the input
// stalls. The instruction and halt counters and the branch-taken flag are updated as each
// result is produced.
// The two configuration registers (pipeline mode at byte address 0, data memory size in
// words at byte address 4) are written over the APB port and should only be changed
// while no instruction is in flight. Problems that would stop a simulator (unknown
// opcode, address out of range, HALT) are reported in the status field of the result.
module risc_execute_stage_top import rxs_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rxs_in_if.sink             in_i,
  rxs_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned CMP_W = (DW > MEMW_W) ? DW : MEMW_W;

  // Configuration registers.
  logic [1:0]        mode_q;
  logic [MEMW_W-1:0] memw_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FUNC;
      memw_q <= MEMW_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MODE:    mode_q <= pwdata[1:0];
        REG_MEMSIZE: memw_q <= pwdata[MEMW_W-1:0];
        default:     mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:    prdata = {30'd0, mode_q};
      REG_MEMSIZE: prdata = {11'd0, memw_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Input register stage.
  logic               s1_valid_q;
  logic               s1_rtype_q;
  logic        [5:0]  s1_op_q;
  logic signed [31:0] s1_rs_q;
  logic signed [31:0] s1_rt_q;
  logic signed [15:0] s1_imm_q;
  logic        [31:0] s1_pc_q;
  logic               advance;
  logic               in_xfer;

  assign advance    = ~out_o.valid | out_o.ready;
  assign in_i.ready = ~s1_valid_q | advance;
  assign in_xfer    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_rtype_q <= in_i.is_r_type;
      s1_op_q    <= in_i.op;
      s1_rs_q    <= in_i.rs_value;
      s1_rt_q    <= in_i.rt_value;
      s1_imm_q   <= in_i.immediate;
      s1_pc_q    <= in_i.pc_in;
    end
  end

  // Execute logic. Operands are sign-extended or truncated to the datapath width.
  logic [DW-1:0] op_a;
  logic [DW-1:0] op_b;
  logic [DW-1:0] op_imm;
  logic [DW-1:0] rhs;
  logic [DW-1:0] alu;
  logic [DW-1:0] addr;
  logic          addr_bad;
  logic [31:0]   br_target;
  logic [31:0]   npc;
  logic          written;
  logic [1:0]    status;
  logic          taken_d;
  logic          halt_inc;
  logic          taken_q;
  logic [31:0]   inst_cnt_q;
  logic [31:0]   halt_cnt_q;
  logic [31:0]   inst_cnt_d;
  logic [31:0]   halt_cnt_d;

  assign op_a   = DW'(s1_rs_q);
  assign op_b   = DW'(s1_rt_q);
  assign op_imm = DW'(s1_imm_q);
  assign rhs    = s1_rtype_q ? op_b : op_imm;

  // Load and store addresses must be non-negative and below the memory size in words.
  assign addr     = op_a + op_imm;
  assign addr_bad = addr[DW-1] | (CMP_W'(addr >> 2) >= CMP_W'(memw_q));

  // Branch targets are relative to the already advanced PC; mode 1 has no forwarding
  // and so backs up two more instruction slots.
  assign br_target = s1_pc_q - PC_STEP - ((mode_q == MODE_PIPE_NOFW) ? PC_PIPE_BACK : 32'd0)
                   + (32'(op_imm) << 2);

  always_comb begin
    alu      = '0;
    npc      = s1_pc_q;
    written  = 1'b0;
    status   = STAT_OK;
    taken_d  = taken_q;
    halt_inc = 1'b0;
    if (s1_rtype_q) begin
      case (s1_op_q)
        OP_ADD:  alu = op_a + rhs;
        OP_SUB:  alu = op_a - rhs;
        OP_MUL:  alu = op_a * rhs;
        OP_OR:   alu = op_a | rhs;
        OP_AND:  alu = op_a & rhs;
        OP_XOR:  alu = op_a ^ rhs;
        default: status = STAT_BAD_OP;
      endcase
    end else begin
      case (s1_op_q)
        OP_ADDI: alu = op_a + rhs;
        OP_SUBI: alu = op_a - rhs;
        OP_MULI: alu = op_a * rhs;
        OP_ORI:  alu = op_a | rhs;
        OP_ANDI: alu = op_a & rhs;
        OP_XORI: alu = op_a ^ rhs;
        OP_LDW, OP_STW: begin
          alu = addr;
          if (addr_bad) begin
            status = STAT_BAD_ADR;
          end
        end
        OP_BZ, OP_BEQ: begin
          taken_d = (s1_op_q == OP_BZ) ? (op_a == '0) : (op_a == op_b);
          if (taken_d) begin
            npc     = br_target;
            written = 1'b1;
          end
        end
        OP_JR: begin
          npc     = 32'(op_a);
          written = 1'b1;
          taken_d = 1'b1;
        end
        OP_HALT: begin
          halt_inc = 1'b1;
          status   = STAT_HALT;
          if ((mode_q == MODE_PIPE_NOFW) || (mode_q == MODE_PIPE_FW)) begin
            npc     = s1_pc_q - PC_STEP;
            written = 1'b1;
          end
        end
        default: status = STAT_BAD_OP;
      endcase
    end
  end

  assign inst_cnt_d = inst_cnt_q + 32'd1;
  assign halt_cnt_d = halt_cnt_q + {31'd0, halt_inc};

  // Result register and architectural state, updated as each result is produced.
  logic out_load;
  assign out_load = s1_valid_q & advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
      taken_q     <= 1'b0;
      inst_cnt_q  <= '0;
      halt_cnt_q  <= '0;
    end else begin
      if (out_load) begin
        out_o.valid <= 1'b1;
        taken_q     <= taken_d;
        inst_cnt_q  <= inst_cnt_d;
        halt_cnt_q  <= halt_cnt_d;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.alu_value         <= 32'(alu);
      out_o.next_pc           <= npc;
      out_o.pc_written        <= written;
      out_o.branch_flag       <= taken_d;
      out_o.status            <= status;
      out_o.instruction_total <= inst_cnt_d;
      out_o.halt_total        <= halt_cnt_d;
    end
  end

endmodule

// File: src/rxs_checker.sv
// Port-level checker for the execute stage and its bind to the top level.
module rxs_checker import rxs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] alu_value_i,
  input logic [1:0]  status_i,
  input logic [31:0] instruction_total_i,
  input logic [31:0] halt_total_i
);

  logic        xfer;
  logic [31:0] last_inst_q;
  logic [31:0] last_halt_q;

  assign xfer = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_inst_q <= '0;
      last_halt_q <= '0;
    end else if (xfer) begin
      last_inst_q <= instruction_total_i;
      last_halt_q <= halt_total_i;
    end
  end

  // A stalled result holds still until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(instruction_total_i)
      && $stable(alu_value_i) && $stable(status_i))
    else $error("stalled result changed");

  // Every result counts exactly one more instruction than the one before.
  a_inst_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> instruction_total_i == last_inst_q + 32'd1)
    else $error("instruction count skipped or repeated");

  // The halt count moves only on a HALT result, and then by one.
  a_halt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> halt_total_i == last_halt_q + {31'd0, status_i == STAT_HALT})
    else $error("halt count out of step");

  // HALT and unknown opcodes carry no ALU result.
  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (status_i == STAT_HALT || status_i == STAT_BAD_OP) |-> alu_value_i == 32'd0)
    else $error("nonzero result on halt or unknown opcode");

endmodule

bind risc_execute_stage_top rxs_checker u_rxs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .alu_value_i         (out_o.alu_value),
  .status_i            (out_o.status),
  .instruction_total_i (out_o.instruction_total),
  .halt_total_i        (out_o.halt_total)
);
